@@ rtl/core/mono_lcd_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// Monochrome LCD controller assertion macros
// Shared property wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MONO_LCD_CONTROLLER_CORE_MACROS_SVH
`define MONO_LCD_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define MLCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mlcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Monochrome LCD controller package
// Geometry constants, register indices, colours, request and control types.
// ----------------------------------------------------------------------------
package mlcd_pkg;

    localparam int unsigned MEM_BYTES      = 4096;
    localparam int unsigned PANEL_WIDTH    = 160;
    localparam int unsigned PANEL_HEIGHT   = 160;
    localparam int unsigned DEFAULT_STRIDE = 20;
    localparam int unsigned DEFAULT_HEIGHT = 160;
    localparam int unsigned DEFAULT_WIDTH  = 160;

    localparam int unsigned ADDR_W   = $clog2(MEM_BYTES);
    localparam int unsigned STRIDE_W = $clog2(DEFAULT_STRIDE + 1);
    localparam int unsigned HEIGHT_W = $clog2(DEFAULT_HEIGHT + 1);
    localparam int unsigned WIDTH_W  = $clog2(DEFAULT_WIDTH + 1);
    localparam int unsigned OFF_W    = 8 + STRIDE_W + 1;
    localparam int unsigned REG_DEPTH = 256;

    localparam logic [7:0]  REG_STRIDE_ALT = 8'h01;
    localparam logic [7:0]  REG_STRIDE     = 8'h12;
    localparam logic [7:0]  REG_HEIGHT     = 8'h14;
    localparam logic [7:0]  VRAM_MISS_BYTE = 8'hFF;
    localparam logic [31:0] COLOUR_OFF     = 32'hffc6d1bd;
    localparam logic [31:0] COLOUR_ON      = 32'hff1c2a20;

    typedef enum logic [2:0] {
        OP_INDEX_WR = 3'd0,
        OP_DATA_WR  = 3'd1,
        OP_INDEX_RD = 3'd2,
        OP_REG_RD   = 3'd3,
        OP_VRAM_WR  = 3'd4,
        OP_VRAM_RD  = 3'd5,
        OP_PIXEL_RD = 3'd6,
        OP_FRAME    = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  reg_index;
        logic [7:0]  write_data;
        logic [15:0] vram_offset;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [31:0] pixel_argb;
        logic [7:0]  width_now;
        logic [7:0]  height_now;
        logic [7:0]  stride_now;
        logic [63:0] changed_writes;
        logic [63:0] frames_seen;
    } t_out_rsp;

    typedef struct packed {
        logic start;
        logic commit;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

@@ rtl/core/mlcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Monochrome LCD controller sequencer
// Runs the video memory clearing pass, then issues start and commit per request.
// ----------------------------------------------------------------------------
`include "mono_lcd_controller_core_macros.svh"

module mlcd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  mlcd_pkg::t_sts i_sts,
    output mlcd_pkg::t_cmd o_cmd
);

    mlcd_pkg::t_state r_state;
    mlcd_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    mlcd_pkg::t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlcd_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            mlcd_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = mlcd_pkg::ST_IDLE;
                end
            end
            mlcd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.start = 1'b1;
                    n_state   = mlcd_pkg::ST_EXEC;
                end
            end
            mlcd_pkg::ST_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.commit = 1'b1;
                    n_state    = mlcd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mlcd_pkg::ST_CLEAR;
            end
        endcase

        priority if (cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = (r_state != mlcd_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `MLCD_ASSERT_NXT(a_start_enters_exec, cmd.start, r_state == mlcd_pkg::ST_EXEC && o_in_stall, "start did not enter exec")
    `MLCD_ASSERT_NXT(a_commit_loads_out, cmd.commit, r_out_valid, "commit did not present a result")
    `MLCD_ASSERT_NXT(a_blocked_holds, r_state == mlcd_pkg::ST_EXEC && r_out_valid && i_out_stall, r_state == mlcd_pkg::ST_EXEC && r_out_valid, "blocked request was lost")

endmodule

@@ rtl/core/mlcd_datapath.sv @@
// ----------------------------------------------------------------------------
// Monochrome LCD controller datapath
// Register file, video memory, geometry decode, counters and result register.
// ----------------------------------------------------------------------------
`include "mono_lcd_controller_core_macros.svh"

module mlcd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlcd_pkg::t_cmd    i_cmd,
    output mlcd_pkg::t_sts    o_sts,
    input  mlcd_pkg::t_in_req i_in,
    output mlcd_pkg::t_out_rsp o_out
);

    logic [7:0]                      r_sel;
    logic [7:0]                      r_rf [mlcd_pkg::REG_DEPTH];
    logic [mlcd_pkg::REG_DEPTH-1:0]  r_rf_vld;
    logic [7:0]                      r_rf_q;
    logic                            r_rf_q_vld;
    logic [7:0]                      r_vram [mlcd_pkg::MEM_BYTES];
    logic [7:0]                      r_vram_q;
    logic [mlcd_pkg::ADDR_W-1:0]     r_clr_addr;
    mlcd_pkg::t_in_req               r_req;
    logic                            r_pix_ok;
    logic                            r_off_ok;
    logic [7:0]                      r_reg_alt;
    logic [7:0]                      r_reg_str;
    logic [7:0]                      r_reg_hgt;
    logic [mlcd_pkg::STRIDE_W-1:0]   r_stride;
    logic [mlcd_pkg::HEIGHT_W-1:0]   r_height;
    logic [mlcd_pkg::WIDTH_W-1:0]    r_width;
    logic [63:0]                     r_dirty;
    logic [63:0]                     r_frames;
    mlcd_pkg::t_out_rsp              r_out;

    logic [mlcd_pkg::OFF_W-1:0]      pix_off;
    logic                            pix_ok;
    logic                            off_ok;
    logic [mlcd_pkg::ADDR_W-1:0]     rd_addr;
    logic [mlcd_pkg::ADDR_W-1:0]     wr_addr;
    logic [7:0]                      wr_data;
    logic                            vram_we;
    logic                            rf_we;
    logic                            geom_wr;
    logic [7:0]                      n_reg_alt;
    logic [7:0]                      n_reg_str;
    logic [7:0]                      n_reg_hgt;
    logic [7:0]                      s_raw;
    logic [8:0]                      h_raw;
    logic [mlcd_pkg::STRIDE_W+2:0]   w_raw;
    logic [mlcd_pkg::STRIDE_W-1:0]   n_stride;
    logic [mlcd_pkg::HEIGHT_W-1:0]   n_height;
    logic [mlcd_pkg::WIDTH_W-1:0]    n_width;
    logic [63:0]                     n_dirty;
    logic [63:0]                     n_frames;
    logic [7:0]                      rd_byte;
    logic [31:0]                     argb;
    logic                            pix_bit;
    mlcd_pkg::t_out_rsp              n_out;

    // pixel address and bounds, from the incoming request
    always_comb begin
        pix_off = mlcd_pkg::OFF_W'(i_in.pixel_y) * mlcd_pkg::OFF_W'(r_stride)
                + mlcd_pkg::OFF_W'(i_in.pixel_x[7:3]);
        pix_ok  = (32'(i_in.pixel_y) < 32'(r_height))
               && (32'(i_in.pixel_y) < mlcd_pkg::PANEL_HEIGHT)
               && (32'(i_in.pixel_x) < mlcd_pkg::PANEL_WIDTH)
               && (32'(i_in.pixel_x[7:3]) < 32'(r_stride))
               && (32'(pix_off) < mlcd_pkg::MEM_BYTES);
        off_ok  = 32'(i_in.vram_offset) < mlcd_pkg::MEM_BYTES;
        rd_addr = (i_in.operation == mlcd_pkg::OP_PIXEL_RD)
                ? mlcd_pkg::ADDR_W'(pix_off) : mlcd_pkg::ADDR_W'(i_in.vram_offset);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req    <= i_in;
            r_pix_ok <= pix_ok;
            r_off_ok <= off_ok;
        end
    end

    // write enables and write port select
    always_comb begin
        vram_we = i_cmd.clear
               || (i_cmd.commit && r_req.operation == mlcd_pkg::OP_VRAM_WR
                   && r_off_ok && r_vram_q != r_req.write_data);
        wr_addr = i_cmd.clear ? r_clr_addr : mlcd_pkg::ADDR_W'(r_req.vram_offset);
        wr_data = i_cmd.clear ? 8'h00 : r_req.write_data;
        rf_we   = i_cmd.commit && r_req.operation == mlcd_pkg::OP_DATA_WR;
    end

    always_ff @(posedge i_clk) begin
        if (vram_we) begin
            r_vram[wr_addr] <= wr_data;
        end
        if (i_cmd.start) begin
            r_vram_q <= r_vram[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[r_sel] <= r_req.write_data;
        end
        if (i_cmd.start) begin
            r_rf_q     <= r_rf[i_in.reg_index];
            r_rf_q_vld <= r_rf_vld[i_in.reg_index];
        end
    end

    // geometry re-decode
    always_comb begin
        geom_wr   = rf_we && (r_sel == mlcd_pkg::REG_STRIDE_ALT
                           || r_sel == mlcd_pkg::REG_STRIDE
                           || r_sel == mlcd_pkg::REG_HEIGHT);
        n_reg_alt = (rf_we && r_sel == mlcd_pkg::REG_STRIDE_ALT) ? r_req.write_data : r_reg_alt;
        n_reg_str = (rf_we && r_sel == mlcd_pkg::REG_STRIDE) ? r_req.write_data : r_reg_str;
        n_reg_hgt = (rf_we && r_sel == mlcd_pkg::REG_HEIGHT) ? r_req.write_data : r_reg_hgt;

        s_raw = (n_reg_str != 8'h00) ? n_reg_str : n_reg_alt;
        h_raw = (n_reg_hgt != 8'h00) ? ({1'b0, n_reg_hgt} + 9'd1)
                                     : 9'(mlcd_pkg::DEFAULT_HEIGHT);

        n_stride = r_stride;
        n_height = r_height;
        n_width  = r_width;
        if (geom_wr) begin
            if (s_raw == 8'h00 || 32'(s_raw) > mlcd_pkg::DEFAULT_STRIDE) begin
                n_stride = mlcd_pkg::STRIDE_W'(mlcd_pkg::DEFAULT_STRIDE);
            end else begin
                n_stride = mlcd_pkg::STRIDE_W'(s_raw);
            end
            if (32'(h_raw) > mlcd_pkg::DEFAULT_HEIGHT) begin
                n_height = mlcd_pkg::HEIGHT_W'(mlcd_pkg::DEFAULT_HEIGHT);
            end else begin
                n_height = mlcd_pkg::HEIGHT_W'(h_raw);
            end
        end
        w_raw = {n_stride, 3'b000};
        if (geom_wr) begin
            if (32'(w_raw) > mlcd_pkg::DEFAULT_WIDTH) begin
                n_width = mlcd_pkg::WIDTH_W'(mlcd_pkg::DEFAULT_WIDTH);
            end else begin
                n_width = mlcd_pkg::WIDTH_W'(w_raw);
            end
        end
    end

    // counters and result
    always_comb begin
        n_dirty  = r_dirty;
        n_frames = r_frames;
        if (vram_we && !i_cmd.clear) begin
            n_dirty = r_dirty + 64'd1;
        end
        if (i_cmd.commit && r_req.operation == mlcd_pkg::OP_FRAME) begin
            n_frames = r_frames + 64'd1;
        end

        pix_bit = r_vram_q[3'd7 - r_req.pixel_x[2:0]];
        argb    = (r_req.operation != mlcd_pkg::OP_PIXEL_RD) ? 32'h0
                : (r_pix_ok && pix_bit) ? mlcd_pkg::COLOUR_ON : mlcd_pkg::COLOUR_OFF;

        unique case (r_req.operation)
            mlcd_pkg::OP_INDEX_RD: rd_byte = r_sel;
            mlcd_pkg::OP_REG_RD:   rd_byte = r_rf_q_vld ? r_rf_q : 8'h00;
            mlcd_pkg::OP_VRAM_RD:  rd_byte = r_off_ok ? r_vram_q : mlcd_pkg::VRAM_MISS_BYTE;
            default:               rd_byte = 8'h00;
        endcase

        n_out.read_byte      = rd_byte;
        n_out.pixel_argb     = argb;
        n_out.width_now      = 8'(n_width);
        n_out.height_now     = 8'(n_height);
        n_out.stride_now     = 8'(n_stride);
        n_out.changed_writes = n_dirty;
        n_out.frames_seen    = n_frames;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel      <= 8'h00;
            r_rf_vld   <= '0;
            r_clr_addr <= '0;
            r_reg_alt  <= 8'h00;
            r_reg_str  <= 8'h00;
            r_reg_hgt  <= 8'h00;
            r_stride   <= mlcd_pkg::STRIDE_W'(mlcd_pkg::DEFAULT_STRIDE);
            r_height   <= mlcd_pkg::HEIGHT_W'(mlcd_pkg::DEFAULT_HEIGHT);
            r_width    <= mlcd_pkg::WIDTH_W'(mlcd_pkg::DEFAULT_WIDTH);
            r_dirty    <= 64'd0;
            r_frames   <= 64'd0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + mlcd_pkg::ADDR_W'(1);
            end
            if (i_cmd.commit && r_req.operation == mlcd_pkg::OP_INDEX_WR) begin
                r_sel <= r_req.reg_index;
            end
            if (rf_we) begin
                r_rf_vld[r_sel] <= 1'b1;
            end
            r_reg_alt <= n_reg_alt;
            r_reg_str <= n_reg_str;
            r_reg_hgt <= n_reg_hgt;
            r_stride  <= n_stride;
            r_height  <= n_height;
            r_width   <= n_width;
            r_dirty   <= n_dirty;
            r_frames  <= n_frames;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == mlcd_pkg::ADDR_W'(mlcd_pkg::MEM_BYTES - 1));
    assign o_out            = r_out;

    `MLCD_ASSERT_IMP(a_stride_range, 1'b1, r_stride != '0 && 32'(r_stride) <= mlcd_pkg::DEFAULT_STRIDE, "stride out of range")
    `MLCD_ASSERT_IMP(a_height_range, 1'b1, r_height != '0 && 32'(r_height) <= mlcd_pkg::DEFAULT_HEIGHT, "height out of range")
    `MLCD_ASSERT_IMP(a_clear_no_write, i_cmd.clear, !i_cmd.commit && !i_cmd.start, "request during clearing pass")

endmodule

@@ rtl/core/mono_lcd_controller_core.sv @@
// ----------------------------------------------------------------------------
// Monochrome LCD controller core
// After reset the block sweeps its video memory to zero, one byte per cycle,
// and stalls requests until all MEM_BYTES (4096) bytes are cleared. After that
// each request first reads the register file or video memory at the addresses
// it carries (the pixel address is formed on the way in), then writes back and
// loads the result register. Each request makes a single memory read and
// write-back, and takes the next only after that write-back; a result waiting
// downstream holds the write-back until the result register is free.
// ----------------------------------------------------------------------------
module mono_lcd_controller_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mlcd_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mlcd_pkg::t_out_rsp o_out
);

    mlcd_pkg::t_cmd cmd;
    mlcd_pkg::t_sts sts;

    mlcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mlcd_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
